// ===== sv/vtdi_pkg.sv =====
// vtdi_pkg: shared constants, types and state codes for the vertex triple indexer
// no dependencies; used by the interfaces, the search controller and the top level
`default_nettype none

package vtdi_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int INDEX_BITS   = 16;

    localparam int FIELD_W  = 16;
    localparam int VNUM_W   = 8;
    localparam int ADDR_W   = $clog2(MAX_VERTICES);
    localparam int COUNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int TRIPLE_W = 3 * INDEX_BITS;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [COUNT_W-1:0]    count_t;

    typedef struct packed {
        index_t pos;
        index_t tex;
        index_t nrm;
    } triple_t;

    typedef struct packed {
        logic [VNUM_W-1:0] vertex_number;
        logic              is_new;
        logic              table_full;
    } result_t;

    typedef struct packed {
        logic    rd_en;
        addr_t   rd_addr;
        logic    wr_en;
        addr_t   wr_addr;
        triple_t wr_data;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INSERT,
        ST_HOLD
    } state_t;

endpackage

`default_nettype wire

// ===== sv/vtdi_in_if.sv =====
// vtdi_in_if: valid/ready channel carrying one face-corner triple word
// depends on vtdi_pkg for the field width
`default_nettype none

interface vtdi_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mesh_start;
    logic [vtdi_pkg::FIELD_W-1:0] pos_index;
    logic [vtdi_pkg::FIELD_W-1:0] tex_index;
    logic [vtdi_pkg::FIELD_W-1:0] normal_index;

    modport source (
        output valid, mesh_start, pos_index, tex_index, normal_index,
        input  ready
    );

    modport sink (
        input  valid, mesh_start, pos_index, tex_index, normal_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/vtdi_out_if.sv =====
// vtdi_out_if: valid/ready channel carrying one vertex number result word
// depends on vtdi_pkg for the vertex number width
`default_nettype none

interface vtdi_out_if;
    logic                        valid;
    logic                        ready;
    logic [vtdi_pkg::VNUM_W-1:0] vertex_number;
    logic                        is_new;
    logic                        table_full;

    modport source (
        output valid, vertex_number, is_new, table_full,
        input  ready
    );

    modport sink (
        input  valid, vertex_number, is_new, table_full,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/vertex_triple_dedup_indexer_core.sv =====
// vertex_triple_dedup_indexer_core: top level of the vertex triple indexer
// a miss searches every filled entry (none after a mesh start) before the insert,
// a hit ends the search at the matching slot
// one word at a time: the next word is taken only once the result is handed on;
// the search reads one table entry per cycle
// reset: fill count cleared, output register empty; table contents left as is
`default_nettype none

module vertex_triple_dedup_indexer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    vtdi_in_if.sink   triple_in,
    vtdi_out_if.source vertex_out
);

    // search controller <-> table ram
    vtdi_pkg::ram_req_t ram_req;
    vtdi_pkg::triple_t  ram_rd_data;
    vtdi_pkg::triple_t  triple_masked;

    // controller result handoff
    logic               res_valid;
    logic               res_ready;
    vtdi_pkg::result_t  result;

    // output register
    logic               out_valid_reg, out_valid_next;
    vtdi_pkg::result_t  out_data_reg,  out_data_next;

    // each index is compared on its low INDEX_BITS bits only
    assign triple_masked.pos = triple_in.pos_index[vtdi_pkg::INDEX_BITS-1:0];
    assign triple_masked.tex = triple_in.tex_index[vtdi_pkg::INDEX_BITS-1:0];
    assign triple_masked.nrm = triple_in.normal_index[vtdi_pkg::INDEX_BITS-1:0];

    vtdi_search_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (triple_in.valid),
        .in_ready    (triple_in.ready),
        .mesh_start  (triple_in.mesh_start),
        .triple_in   (triple_masked),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .result      (result)
    );

    // unique-triple store, one entry read per cycle during the search
    vtdi_table_ram #(
        .DEPTH  (vtdi_pkg::MAX_VERTICES),
        .WIDTH  (vtdi_pkg::TRIPLE_W),
        .ADDR_W (vtdi_pkg::ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register frees the controller while a result word waits
    assign res_ready = !out_valid_reg || vertex_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (vertex_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign vertex_out.valid         = out_valid_reg;
    assign vertex_out.vertex_number = out_data_reg.vertex_number;
    assign vertex_out.is_new        = out_data_reg.is_new;
    assign vertex_out.table_full    = out_data_reg.table_full;

endmodule

`default_nettype wire

// ===== sv/vtdi_table_ram.sv =====
// vtdi_table_ram: generic single-write, single-read synchronous ram
// registered read data, ready in the cycle after the read is asked; no dependencies
`default_nettype none

module vtdi_table_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/vtdi_search_ctrl.sv =====
// vtdi_search_ctrl: linear search sequencer, fill count and insert logic
// depends on vtdi_pkg; drives vtdi_table_ram through a ram_req_t struct
`default_nettype none

module vtdi_search_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input word
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   mesh_start,
    input  wire vtdi_pkg::triple_t      triple_in,
    // table ram
    output vtdi_pkg::ram_req_t          ram_req,
    input  wire vtdi_pkg::triple_t      ram_rd_data,
    // result towards the output register
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output vtdi_pkg::result_t           result
);

    vtdi_pkg::state_t  state_reg,  state_next;
    vtdi_pkg::count_t  count_reg,  count_next;
    vtdi_pkg::addr_t   ptr_reg,    ptr_next;
    vtdi_pkg::triple_t triple_reg, triple_next;
    vtdi_pkg::result_t result_reg, result_next;

    vtdi_pkg::count_t  ptr_inc;
    logic              accept;

    assign accept  = in_valid && in_ready;
    assign ptr_inc = vtdi_pkg::COUNT_W'(ptr_reg) + vtdi_pkg::COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtdi_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        triple_reg <= triple_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        triple_next = triple_reg;
        result_next = result_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_req     = '0;

        unique case (state_reg)
            vtdi_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    triple_next = triple_in;
                    ptr_next    = '0;
                    if (mesh_start)
                    begin
                        count_next = '0;
                    end
                    // empty table: nothing to search
                    if (mesh_start || count_reg == '0)
                    begin
                        state_next = vtdi_pkg::ST_INSERT;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                        state_next      = vtdi_pkg::ST_SEARCH;
                    end
                end
            end

            vtdi_pkg::ST_SEARCH:
            begin
                // read data belongs to the entry at ptr_reg
                if (ram_rd_data == triple_reg)
                begin
                    result_next.vertex_number = vtdi_pkg::VNUM_W'(ptr_reg);
                    result_next.is_new        = 1'b0;
                    result_next.table_full    = 1'b0;
                    state_next                = vtdi_pkg::ST_HOLD;
                end
                else if (ptr_inc < count_reg)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = ptr_inc[vtdi_pkg::ADDR_W-1:0];
                    ptr_next        = ptr_inc[vtdi_pkg::ADDR_W-1:0];
                end
                else
                begin
                    state_next = vtdi_pkg::ST_INSERT;
                end
            end

            vtdi_pkg::ST_INSERT:
            begin
                if (count_reg < vtdi_pkg::COUNT_W'(vtdi_pkg::MAX_VERTICES))
                begin
                    ram_req.wr_en             = 1'b1;
                    ram_req.wr_addr           = count_reg[vtdi_pkg::ADDR_W-1:0];
                    ram_req.wr_data           = triple_reg;
                    count_next                = count_reg + vtdi_pkg::COUNT_W'(1);
                    result_next.vertex_number = vtdi_pkg::VNUM_W'(count_reg);
                    result_next.is_new        = 1'b1;
                    result_next.table_full    = 1'b0;
                end
                else
                begin
                    // table full: triple dropped
                    result_next.vertex_number = '0;
                    result_next.is_new        = 1'b0;
                    result_next.table_full    = 1'b1;
                end
                state_next = vtdi_pkg::ST_HOLD;
            end

            vtdi_pkg::ST_HOLD:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = vtdi_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vtdi_pkg::ST_IDLE;
            end
        endcase
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== tb/sv/vertex_triple_dedup_indexer_core_tb.sv =====
`timescale 1ns / 100ps
// vertex_triple_dedup_indexer_core_tb: self-checking bench for the vertex triple indexer
// depends on vtdi_pkg, vtdi_in_if, vtdi_out_if and vertex_triple_dedup_indexer_core

module vertex_triple_dedup_indexer_core_tb;

    import vtdi_pkg::*;

    localparam int HALF_PERIOD  = 4;
    // worst case is roughly 810 words, each with a full search and a source and a sink
    // stall, so this leaves plenty of headroom
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 700;
    // last stretch of words goes through with no idling on either side
    localparam int TAIL_WORDS   = 60;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        bit               start;
        bit [FIELD_W-1:0] pos;
        bit [FIELD_W-1:0] tex;
        bit [FIELD_W-1:0] nrm;
        bit               drain;    // hold the word back until nothing is in flight
    } corner_word_t;

    logic clk = 1'b0;
    logic rst_n;

    vtdi_in_if  triple_in ();
    vtdi_out_if vertex_out ();

    vertex_triple_dedup_indexer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .triple_in  (triple_in),
        .vertex_out (vertex_out)
    );

    // stimulus waiting to be driven, and vertex numbers waiting to come out
    corner_word_t corner_q   [$];
    result_t      assigned_q [$];

    // own copy of the unique-vertex table for the current mesh
    triple_t mesh_table [MAX_VERTICES];
    int      mesh_fill = 0;

    int           cycles      = 0;
    int           errors      = 0;
    int           in_words    = 0;
    int           mesh_starts = 0;
    int           new_seen    = 0;
    int           hit_seen    = 0;
    int           full_seen   = 0;
    int           src_gap     = 0;
    int           snk_stall   = 0;
    bit           in_fire     = 1'b0;
    corner_word_t next_word;
    result_t      want;

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: linear search of the mesh table, append on a miss
    // ------------------------------------------------------------------
    function automatic result_t number_corner(bit start, triple_t key);
        result_t res;
        int      slot;
        res  = '0;
        slot = -1;
        // a mesh start empties the table before the search
        if (start)
            mesh_fill = 0;
        for (int k = 0; k < mesh_fill; k++)
        begin
            if (slot < 0 && mesh_table[k] == key)
                slot = k;
        end
        if (slot >= 0)
            res.vertex_number = VNUM_W'(slot);
        else if (mesh_fill < MAX_VERTICES)
        begin
            mesh_table[mesh_fill] = key;
            res.vertex_number     = VNUM_W'(mesh_fill);
            res.is_new            = 1'b1;
            mesh_fill++;
        end
        else
            // no room: dropped, number forced to zero
            res.table_full = 1'b1;
        return res;
    endfunction

    function automatic void report(string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("[cycle %0d] mismatch: %s", cycles, msg);
    endfunction

    function automatic bit [FIELD_W-1:0] pick_index();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic void add_word(bit start, bit [FIELD_W-1:0] p, bit [FIELD_W-1:0] t,
                                     bit [FIELD_W-1:0] n, bit drain);
        corner_word_t w;
        w = '{start, p, t, n, drain};
        corner_q.insert(corner_q.size(), w);
    endfunction

    // the cycle count is cut into windows; every third one runs flat out, as does the tail
    function automatic bit idle_allowed();
        return corner_q.size() > TAIL_WORDS && ((cycles / 512) % 3) != 0;
    endfunction

    // ------------------------------------------------------------------
    // cycle count and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still queued, %0d results pending",
                     cycles, corner_q.size(), assigned_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input driver: changes at the falling edge, moves on once a word is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!triple_in.valid || in_fire))
        begin
            if (src_gap != 0)
            begin
                src_gap--;
                triple_in.valid <= 1'b0;
            end
            else if (idle_allowed() && $urandom_range(0, 5) == 0)
            begin
                // idle burst, this cycle included
                src_gap = $urandom_range(0, 13);
                triple_in.valid <= 1'b0;
            end
            else if (corner_q.size() != 0 && !(corner_q[0].drain && assigned_q.size() != 0))
            begin
                next_word = corner_q.pop_front();
                triple_in.valid        <= 1'b1;
                triple_in.mesh_start   <= next_word.start;
                triple_in.pos_index    <= next_word.pos;
                triple_in.tex_index    <= next_word.tex;
                triple_in.normal_index <= next_word.nrm;
            end
            else
                triple_in.valid <= 1'b0;
        end
    end

    // accepted input words feed the predictor straight away
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= triple_in.valid && triple_in.ready;
            if (triple_in.valid && triple_in.ready)
            begin
                in_words++;
                if (triple_in.mesh_start)
                    mesh_starts++;
                assigned_q.insert(assigned_q.size(),
                                  number_corner(triple_in.mesh_start,
                                                {index_t'(triple_in.pos_index),
                                                 index_t'(triple_in.tex_index),
                                                 index_t'(triple_in.normal_index)}));
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: ready stalls in bursts, words checked at the rising edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            vertex_out.ready <= 1'b0;
        else if (snk_stall != 0)
        begin
            snk_stall--;
            vertex_out.ready <= 1'b0;
        end
        else if (idle_allowed() && $urandom_range(0, 4) == 0)
        begin
            snk_stall = $urandom_range(0, 13);
            vertex_out.ready <= 1'b0;
        end
        else
            vertex_out.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && vertex_out.valid && vertex_out.ready)
        begin
            if (assigned_q.size() == 0)
                report($sformatf("result word with nothing pending: vertex %0d new %0b full %0b",
                                 vertex_out.vertex_number, vertex_out.is_new,
                                 vertex_out.table_full));
            else
            begin
                want = assigned_q.pop_front();
                if (vertex_out.vertex_number !== want.vertex_number)
                    report($sformatf("vertex_number expected %0d, got %0d",
                                     want.vertex_number, vertex_out.vertex_number));
                if (vertex_out.is_new !== want.is_new)
                    report($sformatf("is_new expected %0b, got %0b",
                                     want.is_new, vertex_out.is_new));
                if (vertex_out.table_full !== want.table_full)
                    report($sformatf("table_full expected %0b, got %0b",
                                     want.table_full, vertex_out.table_full));
                if (want.table_full)
                    full_seen++;
                else if (want.is_new)
                    new_seen++;
                else
                    hit_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int               rand_base;
        int               fill_at;
        bit               filled;
        int               mesh_len;
        int               pool_size;
        int               pick;
        bit               start;
        bit [FIELD_W-1:0] pool_p [$];
        bit [FIELD_W-1:0] pool_t [$];
        bit [FIELD_W-1:0] pool_n [$];
        corner_word_t     fill_keys [$];

        rst_n                  = 1'b0;
        triple_in.valid        = 1'b0;
        triple_in.mesh_start   = 1'b0;
        triple_in.pos_index    = '0;
        triple_in.tex_index    = '0;
        triple_in.normal_index = '0;
        vertex_out.ready       = 1'b0;

        // directed: extremes, single-field differences, hits, starts on a stored triple
        add_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // first word after reset
        add_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // hit on slot 0
        add_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_word(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);  // differs in position only
        add_word(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);  // texture only
        add_word(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);  // normal only
        add_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_word(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        add_word(1'b0, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        add_word(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
        add_word(1'b0, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        // new mesh on a triple that the old mesh held, sent only once drained
        add_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        add_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_word(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_word(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // back-to-back starts
        add_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_word(1'b0, 16'h8000, 16'h0001, 16'h8001, 1'b0);
        add_word(1'b0, 16'h0001, 16'h8000, 16'h8001, 1'b0);

        // random meshes with heavy reuse, one of them filling the table
        rand_base = corner_q.size();
        fill_at   = $urandom_range(100, 300);
        filled    = 1'b0;
        while (corner_q.size() - rand_base < RANDOM_WORDS)
        begin
            if (!filled && corner_q.size() - rand_base >= fill_at)
            begin
                filled = 1'b1;
                fill_keys.delete();
                // distinct low position bytes keep every stored triple unique
                for (int s = 0; s < MAX_VERTICES; s++)
                begin
                    if (s > 0 && $urandom_range(0, 7) == 0)
                    begin
                        pick = $urandom_range(0, s - 1);
                        add_word(1'b0, fill_keys[pick].pos, fill_keys[pick].tex,
                                 fill_keys[pick].nrm, 1'b0);
                    end
                    next_word = '{s == 0, {8'($urandom), 8'(s)}, pick_index(), pick_index(),
                                  1'b0};
                    fill_keys.insert(fill_keys.size(), next_word);
                    corner_q.insert(corner_q.size(), next_word);
                end
                // table now full: first and last slot still found, new ones dropped
                add_word(1'b0, fill_keys[0].pos, fill_keys[0].tex, fill_keys[0].nrm, 1'b0);
                add_word(1'b0, fill_keys[MAX_VERTICES-1].pos, fill_keys[MAX_VERTICES-1].tex,
                         fill_keys[MAX_VERTICES-1].nrm, 1'b0);
                for (int j = 0; j < 20; j++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        pick = $urandom_range(0, MAX_VERTICES - 1);
                        add_word(1'b0, fill_keys[pick].pos, fill_keys[pick].tex,
                                 fill_keys[pick].nrm, 1'b0);
                    end
                    else
                        add_word(1'b0, pick_index(), pick_index(), pick_index(), 1'b0);
                end
            end
            else
            begin
                mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 90)
                                                        : $urandom_range(1, 40);
                pool_p.delete();
                pool_t.delete();
                pool_n.delete();
                pool_size = $urandom_range(1, 8);
                for (int j = 0; j < pool_size; j++)
                    pool_p.insert(pool_p.size(), pick_index());
                pool_size = $urandom_range(1, 8);
                for (int j = 0; j < pool_size; j++)
                    pool_t.insert(pool_t.size(), pick_index());
                pool_size = $urandom_range(1, 8);
                for (int j = 0; j < pool_size; j++)
                    pool_n.insert(pool_n.size(), pick_index());
                for (int j = 0; j < mesh_len; j++)
                begin
                    // mostly a clean start per mesh, now and then a stray one mid-mesh
                    start = (j == 0) ? ($urandom_range(0, 7) != 0)
                                     : ($urandom_range(0, 39) == 0);
                    if ($urandom_range(0, 9) == 0)
                        add_word(start, pick_index(), pick_index(), pick_index(),
                                 $urandom_range(0, 149) == 0);
                    else
                        add_word(start,
                                 pool_p[$urandom_range(0, pool_p.size() - 1)],
                                 pool_t[$urandom_range(0, pool_t.size() - 1)],
                                 pool_n[$urandom_range(0, pool_n.size() - 1)],
                                 $urandom_range(0, 149) == 0);
                end
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (corner_q.size() != 0 || triple_in.valid || assigned_q.size() != 0)
            @(posedge clk);
        // one full search time for any stray word to show up
        repeat (MAX_VERTICES + 8) @(posedge clk);

        $display("run covered %0d corner words over %0d mesh starts in %0d cycles",
                 in_words, mesh_starts, cycles);
        $display("results: %0d new vertices, %0d repeats, %0d dropped on a full table",
                 new_seen, hit_seen, full_seen);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
